// File: design/sse_pkg.sv
// Shared constants and the sequencer state type of the selection sort engine.
`timescale 1ns / 1ps

package sse_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_SCAN,
		ST_DRAIN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_ADVANCE,
		ST_EMIT_RD,
		ST_EMIT_LD
	} sse_state_t;

endpackage

// File: design/sse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module sse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/selection_sort_engine_unit.sv
// Top level of the selection sort engine: collects a run, sorts it in place, streams it out.
`timescale 1ns / 1ps

// Channel  Direction  Signals                        Payload
// -------  ---------  -----------------------------  ------------------------------------------
// s        in         s_tvalid s_tready s_tdata      tdata[31:0] value (signed)
//                     s_tlast                        tlast = is_final
// m        out        m_tvalid m_tready m_tdata      tdata[31:0] sorted_value (signed)
//                     m_tlast m_tuser                tlast = end_of_run, tuser[0] = overflowed
//
// While a run is collected, the block takes one request per cycle and writes it into the
// element RAM. The request marked last starts the sort: for each position a single signed
// comparator scans the remainder through the RAM read port, one element per cycle, and the
// minimum found is swapped into that position. Each sorted element is then read from the
// RAM, loaded into the output register and held there until m_tready takes it.
// The block takes no input request from the last request of a run until the last result has
// been taken. Reset (arst_n, async, active low) empties the run and clears the overflow mark;
// the RAM itself is never cleared, since only written entries are read.

module selection_sort_engine_unit
	import sse_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // [31:0] value
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,  // [31:0] sorted_value
	output logic              m_tlast,
	output logic [0:0]        m_tuser   // [0] overflowed
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	sse_state_t state_q, state_nxt;

	logic [CW-1:0]     cnt_q;      // number of stored elements
	logic              ovf_q;      // an element of this run was dropped
	logic [IW-1:0]     pos_q;      // position being filled by the sort
	logic [IW-1:0]     probe_q;    // next RAM address to read (scan or emit)
	logic [IW-1:0]     best_idx_q;
	logic [DATA_W-1:0] best_val_q;
	logic [DATA_W-1:0] pos_val_q;  // value that sat at pos_q before the swap
	logic              rd_vld_s1;
	logic [IW-1:0]     rd_idx_s1;

	logic              out_vld_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_last_q;
	logic              out_ovf_q;

	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [IW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic              in_acc;
	logic              room;
	logic [CW-1:0]     cnt_after;
	logic              scan_end;
	logic              more_pos;
	logic              emit_last;

	sse_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_acc    = s_tvalid && s_tready;
	assign room      = (cnt_q < CW'(CAPACITY));
	assign cnt_after = room ? (cnt_q + CW'(1)) : cnt_q;
	// The scan ends once the last stored element has been addressed.
	assign scan_end  = ({1'b0, probe_q} == (IW + 1)'(cnt_q - CW'(1)));
	// Another position needs a scan when at least two elements remain behind it.
	assign more_pos  = ((CW + 1)'(pos_q) + (CW + 1)'(2) < (CW + 1)'(cnt_q));
	assign emit_last = ((CW + 1)'(probe_q) + (CW + 1)'(1) == (CW + 1)'(cnt_q));

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_COLLECT: begin
				if (in_acc && s_tlast) begin
					if (cnt_after > CW'(1)) begin
						state_nxt = ST_SCAN;
					end else if (cnt_after == CW'(1)) begin
						state_nxt = ST_EMIT_RD;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_SWAP_A;
			end
			ST_SWAP_A: begin
				state_nxt = (best_idx_q != pos_q) ? ST_SWAP_B : ST_ADVANCE;
			end
			ST_SWAP_B: begin
				state_nxt = ST_ADVANCE;
			end
			ST_ADVANCE: begin
				state_nxt = more_pos ? ST_SCAN : ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				state_nxt = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (out_vld_q && m_tready) begin
					state_nxt = out_last_q ? ST_COLLECT : ST_EMIT_RD;
				end
			end
			default: begin
				state_nxt = ST_COLLECT;
			end
		endcase
	end

	// RAM port and handshake control.
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[IW-1:0];
		ram_wdata = s_tdata;
		ram_raddr = probe_q;
		unique case (state_q)
			ST_COLLECT: begin
				s_tready = 1'b1;
				ram_we   = s_tvalid && room;
			end
			ST_SWAP_A: begin
				ram_we    = (best_idx_q != pos_q);
				ram_waddr = pos_q;
				ram_wdata = best_val_q;
			end
			ST_SWAP_B: begin
				ram_we    = 1'b1;
				ram_waddr = best_idx_q;
				ram_wdata = pos_val_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_COLLECT;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			pos_q     <= '0;
			probe_q   <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_COLLECT: begin
					pos_q   <= '0;
					probe_q <= '0;
					if (in_acc) begin
						cnt_q <= cnt_after;
						if (!room) begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (!scan_end) begin
						probe_q <= probe_q + IW'(1);
					end
				end
				ST_ADVANCE: begin
					if (more_pos) begin
						pos_q   <= pos_q + IW'(1);
						probe_q <= pos_q + IW'(1);
					end else begin
						probe_q <= '0;
					end
				end
				ST_EMIT_LD: begin
					// The first cycle here loads the read data; the result is offered after that.
					if (!out_vld_q) begin
						out_vld_q <= 1'b1;
					end else if (m_tready) begin
						out_vld_q <= 1'b0;
						if (out_last_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							probe_q <= '0;
						end else begin
							probe_q <= probe_q + IW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Shared comparator: the first element read at a position seeds the minimum, later ones
	// replace it only when strictly smaller, so the first minimum wins.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= probe_q;
		if (rd_vld_s1) begin
			if (rd_idx_s1 == pos_q) begin
				best_val_q <= ram_rdata;
				best_idx_q <= rd_idx_s1;
				pos_val_q  <= ram_rdata;
			end else if ($signed(best_val_q) > $signed(ram_rdata)) begin
				best_val_q <= ram_rdata;
				best_idx_q <= rd_idx_s1;
			end
		end
		if ((state_q == ST_EMIT_LD) && !out_vld_q) begin
			out_data_q <= ram_rdata;
			out_last_q <= emit_last;
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

endmodule

// File: test/tb_selection_sort_engine_unit.sv
// Self-checking testbench for the selection sort engine: random runs, bursty requests, stalled output.
`timescale 1ns / 1ps

module tb_selection_sort_engine_unit;
	import sse_pkg::*;

	localparam int STORE_DEPTH  = CAPACITY_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 400;
	localparam int TARGET_ITEMS = 410;

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		logic signed [DATA_W-1:0] elem;
		logic                     final_mark;
	} sort_request_t;

	typedef struct {
		logic signed [DATA_W-1:0] elem;
		logic                     run_end;
		logic                     dropped;
	} sorted_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;  // [31:0] value
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;       // [31:0] sorted_value
	logic              m_tlast;
	logic [0:0]        m_tuser;       // [0] overflowed

	sort_request_t  pending_requests[$];
	sorted_result_t sorted_expect[$];

	// Shadow of the run being collected by the block.
	logic signed [DATA_W-1:0] run_store[STORE_DEPTH];
	int                       run_count = 0;
	logic                     run_dropped = 1'b0;

	int  error_count = 0;
	int  cycle_count = 0;
	int  gap_left = 0;
	int  burst_left = 1;
	int  ready_phase = 0;
	logic [7:0] ready_pattern = 8'hFF;

	selection_sort_engine_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Store or drop one accepted element; a final element sorts the run and queues its output.
	task automatic collect_and_sort(input logic signed [DATA_W-1:0] elem, input logic final_mark);
		int pos;
		int best;
		logic signed [DATA_W-1:0] held;
		sorted_result_t res;
		if (run_count < STORE_DEPTH) begin
			run_store[run_count] = elem;
			run_count++;
		end else begin
			run_dropped = 1'b1;
		end
		if (final_mark) begin
			for (pos = 0; pos + 1 < run_count; pos++) begin
				best = pos;
				for (int probe = pos + 1; probe < run_count; probe++) begin
					if (run_store[best] > run_store[probe])
						best = probe;
				end
				held = run_store[pos];
				run_store[pos] = run_store[best];
				run_store[best] = held;
			end
			for (pos = 0; pos < run_count; pos++) begin
				res.elem = run_store[pos];
				res.run_end = (pos + 1 == run_count);
				res.dropped = run_dropped;
				sorted_expect.push_back(res);
			end
			run_count = 0;
			run_dropped = 1'b0;
		end
	endtask

	function automatic logic signed [DATA_W-1:0] pick_element();
		logic signed [DATA_W-1:0] corner[7];
		corner = '{VAL_MIN, VAL_MAX, 32'sd0, -32'sd1, 32'sd1, VAL_MIN + 1, VAL_MAX - 1};
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 8)) - 4;  // tight range, many duplicates
			1: return corner[$urandom_range(0, 6)];
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_run(input int len);
		sort_request_t req;
		for (int k = 0; k < len; k++) begin
			req.elem = pick_element();
			req.final_mark = (k == len - 1);
			pending_requests.push_back(req);
		end
	endtask

	task automatic queue_fixed(input logic signed [DATA_W-1:0] elems[$]);
		sort_request_t req;
		foreach (elems[k]) begin
			req.elem = elems[k];
			req.final_mark = (k == elems.size() - 1);
			pending_requests.push_back(req);
		end
	endtask

	// Sender: holds a request until it is taken, then may open a gap between bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				collect_and_sort(s_tdata, s_tlast);
				void'(pending_requests.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_requests[0].elem;
					s_tlast <= pending_requests[0].final_mark;
					if (burst_left <= 1) begin
						case ($urandom_range(0, 9))
							0, 1: begin
								burst_left = $urandom_range(30, 60);
								gap_left = 0;
							end
							2, 3, 4: begin
								burst_left = $urandom_range(1, 12);
								gap_left = $urandom_range(1, 4);
							end
							5: begin
								burst_left = $urandom_range(1, 6);
								gap_left = $urandom_range(5, 30);
							end
							default: begin
								burst_left = $urandom_range(1, 12);
								gap_left = 0;
							end
						endcase
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: cycles through an 8-bit ready pattern, picking a new one on each wrap.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ready_pattern[ready_phase];
			ready_phase++;
			if (ready_phase == 8) begin
				ready_phase = 0;
				if ($urandom_range(0, 3) == 0)
					ready_pattern = 8'hFF;
				else
					ready_pattern = $urandom;
				if (ready_pattern == 8'h00)
					ready_pattern = 8'h01;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (sorted_expect.size() == 0) begin
				$error("unexpected result: sorted_value %0d", $signed(m_tdata));
				error_count++;
			end else begin
				if (m_tdata !== sorted_expect[0].elem) begin
					$error("sorted_value mismatch: expected %0d, actual %0d",
						sorted_expect[0].elem, $signed(m_tdata));
					error_count++;
				end
				if (m_tlast !== sorted_expect[0].run_end) begin
					$error("end_of_run mismatch: expected %0b, actual %0b",
						sorted_expect[0].run_end, m_tlast);
					error_count++;
				end
				if (m_tuser[0] !== sorted_expect[0].dropped) begin
					$error("overflowed mismatch: expected %0b, actual %0b",
						sorted_expect[0].dropped, m_tuser[0]);
					error_count++;
				end
				void'(sorted_expect.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int len;
		int queued;
		logic signed [DATA_W-1:0] full_run[$];

		// Single element, then extremes and duplicates in short runs.
		queue_fixed('{VAL_MIN});
		queue_fixed('{VAL_MAX, VAL_MIN, 32'sd0});
		queue_fixed('{32'sd5, -32'sd5, 32'sd5, -32'sd5});
		// Exactly a full store, in descending order.
		full_run = '{VAL_MAX};
		for (int k = 1; k < STORE_DEPTH - 1; k++)
			full_run.push_back(32'sd1000 - k * 137);
		full_run.push_back(VAL_MIN);
		queue_fixed(full_run);

		queued = pending_requests.size();
		while (queued < TARGET_ITEMS) begin
			case ($urandom_range(0, 9))
				0: len = STORE_DEPTH;
				1: len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);  // overflow, final dropped
				2, 3: len = $urandom_range(9, STORE_DEPTH - 1);
				default: len = $urandom_range(1, 8);
			endcase
			queue_run(len);
			queued += len;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() > 0 || sorted_expect.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
